// File: rtl/pspf_pkg.sv
// shared types and constants for the particle sensor frame parser
package pspf_pkg;

  localparam int FRAME_BYTES_DEF    = 32;
  localparam int READINGS           = 6;
  localparam int FIRST_READING_BYTE = 4;
  localparam int POS_W              = 6;
  localparam int IDX_W              = 3;

  localparam logic [7:0] START_FIRST_RST  = 8'd66;
  localparam logic [7:0] START_SECOND_RST = 8'd77;

  // configuration register indexes
  localparam logic [7:0] REG_START_FIRST  = 8'd0;
  localparam logic [7:0] REG_START_SECOND = 8'd1;

  typedef enum logic [1:0] {
    PH_HUNT      = 2'd0,
    PH_GOT_FIRST = 2'd1,
    PH_COLLECT   = 2'd2
  } phase_t;

  // per-byte control from the sync tracker to the capture stage
  typedef struct packed {
    logic             store_wr;
    logic [IDX_W-1:0] store_idx;
    logic             store_low;
    logic             check_wr;
    logic             done;
  } capture_ctrl_t;

endpackage

// File: rtl/pspf_sync.sv
// frame sync tracker: start byte hunt, byte position and running sum
module pspf_sync #(
  parameter int FRAME_BYTES = pspf_pkg::FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             start_first,
  input  logic [7:0]             start_second,
  output pspf_pkg::capture_ctrl_t ctrl,
  output logic [15:0]            sum
);

  localparam logic [pspf_pkg::POS_W-1:0] CHECK_POS =
    pspf_pkg::POS_W'(FRAME_BYTES - 2);
  localparam logic [pspf_pkg::POS_W-1:0] FIRST_POS =
    pspf_pkg::POS_W'(pspf_pkg::FIRST_READING_BYTE);
  localparam logic [pspf_pkg::POS_W-1:0] LAST_READ_POS =
    pspf_pkg::POS_W'(pspf_pkg::FIRST_READING_BYTE + 2 * pspf_pkg::READINGS - 1);

  pspf_pkg::phase_t              phase, phase_next;
  logic [pspf_pkg::POS_W-1:0]    pos, pos_next;
  logic [15:0]                   sum_next;
  logic [pspf_pkg::POS_W-1:0]    rel;

  assign rel = pos - FIRST_POS;

  always_comb begin
    phase_next = pspf_pkg::PH_HUNT;
    pos_next   = '0;
    sum_next   = '0;
    case (phase)
      pspf_pkg::PH_GOT_FIRST: begin
        if (rx_byte == start_second) begin
          phase_next = pspf_pkg::PH_COLLECT;
          pos_next   = pspf_pkg::POS_W'(2);
          sum_next   = sum + {8'd0, rx_byte};
        end
      end
      pspf_pkg::PH_COLLECT: begin
        if (pos < CHECK_POS) begin
          phase_next = pspf_pkg::PH_COLLECT;
          pos_next   = pos + 1'b1;
          sum_next   = sum + {8'd0, rx_byte};
        end else if (pos == CHECK_POS) begin
          phase_next = pspf_pkg::PH_COLLECT;
          pos_next   = pos + 1'b1;
          sum_next   = sum;
        end
      end
      default: begin
        if (rx_byte == start_first) begin
          phase_next = pspf_pkg::PH_GOT_FIRST;
          pos_next   = pspf_pkg::POS_W'(1);
          sum_next   = {8'd0, rx_byte};
        end
      end
    endcase
  end

  always_comb begin
    ctrl           = '0;
    ctrl.store_idx = rel[pspf_pkg::IDX_W:1];
    ctrl.store_low = rel[0];
    case (phase)
      pspf_pkg::PH_COLLECT: begin
        ctrl.store_wr = (pos < CHECK_POS) && (pos inside {[FIRST_POS:LAST_READ_POS]});
        ctrl.check_wr = (pos == CHECK_POS);
        ctrl.done     = (pos > CHECK_POS);
      end
      default: begin
        ctrl.store_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pspf_pkg::PH_HUNT;
      pos   <= '0;
      sum   <= '0;
    end else if (fire) begin
      phase <= phase_next;
      pos   <= pos_next;
      sum   <= sum_next;
    end
  end

endmodule

// File: rtl/pspf_capture.sv
// reading capture and checksum compare, forms the frame result
module pspf_capture (
  input  logic                    clk,
  input  logic                    fire,
  input  logic [7:0]              rx_byte,
  input  pspf_pkg::capture_ctrl_t ctrl,
  input  logic [15:0]             sum,
  output logic                    status,
  output logic [15:0]             readings [pspf_pkg::READINGS]
);

  logic [15:0] store [pspf_pkg::READINGS];
  logic [7:0]  check_high;
  logic        ok;

  assign ok     = ({check_high, rx_byte} == sum);
  assign status = !ok;

  always_comb begin
    for (int i = 0; i < pspf_pkg::READINGS; i++) begin
      readings[i] = ok ? store[i] : 16'd0;
    end
  end

  // payload storage, no reset: every entry is written before frame end
  always_ff @(posedge clk) begin
    if (fire && ctrl.store_wr) begin
      if (ctrl.store_low) begin
        store[ctrl.store_idx] <= store[ctrl.store_idx] | {8'd0, rx_byte};
      end else begin
        store[ctrl.store_idx] <= {rx_byte, 8'd0};
      end
    end
    if (fire && ctrl.check_wr) begin
      check_high <= rx_byte;
    end
  end

endmodule

// File: rtl/particle_sensor_frame_parser.sv
// top level of the particle sensor frame parser
// Takes received serial bytes one beat at a time and emits one result beat per
// complete frame: a status bit and six big-endian 16-bit particle readings.
// The parser hunts for start_first, then needs start_second on the
// very next byte, then collects the rest of a FRAME_BYTES frame. A wrapping
// 16-bit sum covers every byte but the last two, which carry the checksum
// high byte first. On a mismatch the status is 1 and all readings are zero.
// Each byte sits in the input register, the sync tracker and capture logic
// work on it there, and a frame result is registered in the output register
// when its last byte is processed. A new byte can be accepted every cycle;
// the input side stalls only when the last byte of a frame finds the output
// register still holding an untaken result. The configuration port is always
// ready and should be written only while idle.
module particle_sensor_frame_parser #(
  parameter int FRAME_BYTES = pspf_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_status,
  output logic [15:0] pm1_std,
  output logic [15:0] pm25_std,
  output logic [15:0] pm10_std,
  output logic [15:0] pm1_atm,
  output logic [15:0] pm25_atm,
  output logic [15:0] pm10_atm_out,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // configuration registers
  logic [7:0] start_first;
  logic [7:0] start_second;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_first  <= pspf_pkg::START_FIRST_RST;
      start_second <= pspf_pkg::START_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pspf_pkg::REG_START_FIRST:  start_first  <= cfg_data;
        pspf_pkg::REG_START_SECOND: start_second <= cfg_data;
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_byte;

  // per-byte processing
  pspf_pkg::capture_ctrl_t ctrl;
  logic [15:0]             sum;
  logic                    res_status;
  logic [15:0]             res_read [pspf_pkg::READINGS];
  logic                    out_free;
  logic                    proc_fire;

  // output register can take a result when empty or being drained this cycle
  assign out_free  = !out_valid || !out_stall;
  // a byte that ends a frame waits for room in the output register
  assign proc_fire = in_q_valid && (!ctrl.done || out_free);
  assign in_stall  = in_q_valid && !proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte <= rx_byte;
    end
  end

  pspf_sync #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_sync (
    .clk          (clk),
    .rst          (rst),
    .fire         (proc_fire),
    .rx_byte      (in_q_byte),
    .start_first  (start_first),
    .start_second (start_second),
    .ctrl         (ctrl),
    .sum          (sum)
  );

  pspf_capture u_capture (
    .clk      (clk),
    .fire     (proc_fire),
    .rx_byte  (in_q_byte),
    .ctrl     (ctrl),
    .sum      (sum),
    .status   (res_status),
    .readings (res_read)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= proc_fire && ctrl.done;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && ctrl.done) begin
      frame_status <= res_status;
      pm1_std      <= res_read[0];
      pm25_std     <= res_read[1];
      pm10_std     <= res_read[2];
      pm1_atm      <= res_read[3];
      pm25_atm     <= res_read[4];
      pm10_atm_out <= res_read[5];
    end
  end

`ifndef SYNTHESIS
  // a finished frame never overwrites a result still waiting to be taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && ctrl.done) |-> out_free)
    else $error("frame result overwrote a pending result");

  // a checksum failure carries all-zero readings
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status) |->
      (pm1_std == 16'd0 && pm25_std == 16'd0 && pm10_std == 16'd0 &&
       pm1_atm == 16'd0 && pm25_atm == 16'd0 && pm10_atm_out == 16'd0))
    else $error("readings not cleared on checksum error");

  // the input side only stalls on a frame-ending byte blocked by the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_q_valid && ctrl.done && out_valid && out_stall))
    else $error("input stalled without a blocked frame result");
`endif

endmodule
